>>> design/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the status frame deframer.
// ---------------------------------------------------------------------------
package sfd_pkg;

    localparam int POS_W        = 5;
    localparam int STORE_DEPTH  = 16;
    localparam int STORE_IDX_W  = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int OUT_DATA_W   = 160;

    localparam logic [POS_W-1:0] FRAME_LAST = 5'd20;
    localparam logic [POS_W-1:0] POS_IDLE   = 5'd21;
    localparam logic [POS_W-1:0] STORE_BASE = 5'd4;
    localparam logic [POS_W-1:0] HDR_LO_POS = 5'd1;
    localparam logic [POS_W-1:0] HDR_HI_POS = 5'd0;

    localparam logic [15:0] HEADER_RESET = 16'hAABB;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_SUM    = 2'd2
    } status_t;

    // one finished frame: verdict plus the raw bytes 4..19, byte 4 at index 0
    typedef struct packed {
        status_t                          status;
        logic [STORE_DEPTH-1:0][7:0]      payload;
    } frame_rec_t;

endpackage

>>> design/status_frame_deframer.sv
// ---------------------------------------------------------------------------
// status_frame_deframer
// Charge controller status reply deframer, one byte per transfer.
// ---------------------------------------------------------------------------
// Takes one byte per clock. A byte with tuser set starts a burst; bytes 0 and
// 1 are checked against the header register, bytes 2..19 are summed mod 256
// and compared with byte 20. Byte 20 yields one result that is written into
// the frame queue and then moved into the output register, where it sits
// until taken. The input only stalls when the frame queue (QUEUE_DEPTH
// records) is full behind a stalled output. Short bursts and bytes past 20
// give nothing. Failed frames carry a status code in tuser and all-zero
// tdata. The header register may be written at any time through the cfg
// channel, which never stalls.
// ---------------------------------------------------------------------------
module status_frame_deframer
#(
    parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [15:0]                      cfg_data,      // expected_header
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // rx_byte
    input  logic [0:0]                       s_axis_tuser,  // burst_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pv_voltage_dv[15:0], pv_current_da[31:16], pv_power_cw[63:32],
    // battery_voltage_dv[79:64], temperature_dc[95:80], load_current_da[111:96],
    // daily_energy_ckwh[127:112], total_energy_dkwh[143:128],
    // run_mode[151:144], fault_code[159:152]
    output logic [sfd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                       m_axis_tuser   // frame_status
);

    logic                   rec_push, rec_ready, head_valid, pop;
    sfd_pkg::frame_rec_t    rec_data, head_data;

    sfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_start  (s_axis_tuser[0]),
        .rec_push  (rec_push),
        .rec_data  (rec_data),
        .rec_ready (rec_ready)
    );

    sfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rec_push),
        .push_data  (rec_data),
        .push_ready (rec_ready),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    sfd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser)
    );

endmodule

>>> design/sfd_front.sv
// ---------------------------------------------------------------------------
// sfd_front
// Byte tracker: header compare, running sum, payload capture and verdict.
// Emits one frame record on byte 20.
// ---------------------------------------------------------------------------
module sfd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_start,
    output logic                 rec_push,
    output sfd_pkg::frame_rec_t  rec_data,
    input  logic                 rec_ready
);

    logic [15:0]                            header_reg;
    logic [sfd_pkg::POS_W-1:0]              pos_reg, pos_next;
    logic [7:0]                             sum_reg, sum_next;
    logic                                   match_reg, match_next;
    logic [sfd_pkg::STORE_DEPTH-1:0][7:0]   store_reg, store_next;
    logic [sfd_pkg::POS_W-1:0]              pos;
    logic [sfd_pkg::POS_W-1:0]              rel;
    logic                                   accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = rec_ready;
    assign accept    = in_valid && in_ready;

    // a start flag restarts the burst on this very byte
    assign pos = in_start ? '0 : pos_reg;
    assign rel = pos - sfd_pkg::STORE_BASE;

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        match_next = match_reg;
        store_next = store_reg;
        if (accept && pos <= sfd_pkg::FRAME_LAST)
        begin
            pos_next = pos + 5'd1;
            case (pos)
                sfd_pkg::HDR_HI_POS:
                begin
                    sum_next   = '0;
                    match_next = (in_byte == header_reg[15:8]);
                end
                sfd_pkg::HDR_LO_POS:
                begin
                    match_next = match_reg && (in_byte == header_reg[7:0]);
                end
                default:
                begin
                    if (pos < sfd_pkg::FRAME_LAST)
                    begin
                        sum_next = sum_reg + in_byte;
                        if (pos >= sfd_pkg::STORE_BASE)
                        begin
                            store_next[rel[sfd_pkg::STORE_IDX_W-1:0]] = in_byte;
                        end
                    end
                end
            endcase
        end
    end

    assign rec_push = accept && (pos == sfd_pkg::FRAME_LAST);

    always_comb
    begin
        rec_data.payload = store_reg;
        if (!match_reg)
        begin
            rec_data.status = sfd_pkg::ST_BAD_HEADER;
        end
        else if (in_byte != sum_reg)
        begin
            rec_data.status = sfd_pkg::ST_BAD_SUM;
        end
        else
        begin
            rec_data.status = sfd_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= sfd_pkg::HEADER_RESET;
            pos_reg    <= sfd_pkg::POS_IDLE;
            sum_reg    <= '0;
            match_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                header_reg <= cfg_data;
            end
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    a_idle_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |=> pos_reg == sfd_pkg::POS_IDLE)
        else $error("byte tracker not idle after final byte");

    a_stray_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_start && pos_reg == sfd_pkg::POS_IDLE) |->
        (!rec_push && pos_next == sfd_pkg::POS_IDLE))
        else $error("stray byte changed tracker state");

endmodule

>>> design/sfd_queue.sv
// ---------------------------------------------------------------------------
// sfd_queue
// Short register queue of frame records between front and back.
// ---------------------------------------------------------------------------
module sfd_queue
#(
    parameter int DEPTH = sfd_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfd_pkg::frame_rec_t  push_data,
    output logic                 push_ready,
    output logic                 head_valid,
    output sfd_pkg::frame_rec_t  head_data,
    input  logic                 pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfd_pkg::frame_rec_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue overfilled");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("record pushed into full queue");

endmodule

>>> design/sfd_back.sv
// ---------------------------------------------------------------------------
// sfd_back
// Unpacks a frame record into big-endian fields, forms PV power and holds
// the result in the output register.
// ---------------------------------------------------------------------------
module sfd_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  sfd_pkg::frame_rec_t               head_data,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sfd_pkg::OUT_DATA_W-1:0]    out_data,
    output logic [1:0]                        out_status
);

    logic                               valid_reg;
    logic [sfd_pkg::OUT_DATA_W-1:0]     data_reg, data_next;
    sfd_pkg::status_t                   status_reg;
    logic [15:0]                        volt, curr;
    logic [31:0]                        power;
    logic [sfd_pkg::STORE_DEPTH-1:0][7:0] p;

    assign p     = head_data.payload;
    assign volt  = {p[0], p[1]};
    assign curr  = {p[2], p[3]};
    assign power = 32'(volt) * 32'(curr);
    assign pop   = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        data_next = {p[15],              // fault code, byte 19
                     p[10],              // working mode, byte 14
                     p[13], p[14],       // total energy
                     p[11], p[12],       // daily energy
                     p[8],  p[9],        // load current
                     p[6],  p[7],        // temperature
                     p[4],  p[5],        // battery voltage
                     power, curr, volt};
        if (head_data.status != sfd_pkg::ST_OK)
        begin
            data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg   <= data_next;
            status_reg <= head_data.status;
        end
    end

    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_status = status_reg;

    a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg != sfd_pkg::ST_OK) |-> data_reg == '0)
        else $error("failed frame carries data");

endmodule
